/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cond implies prop.
`define ASSERT_IMP(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("assertion failed");

// Next-cycle implication: cond implies prop.
`define ASSERT_NXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("assertion failed");

`endif

/* rtl/q8bd_pkg.sv */
// ---------------------------------------------------------------------------
// q8bd_pkg
// Types, constants and float32 helpers for the block dot accumulator.
// ---------------------------------------------------------------------------
package q8bd_pkg;

	localparam int BLOCK_ELEMS     = 32;
	localparam int BYTES_PER_WORD  = 8;
	localparam int WORDS_PER_BLOCK = BLOCK_ELEMS / BYTES_PER_WORD;
	localparam int CNT_W           = $clog2(WORDS_PER_BLOCK);
	localparam int ISUM_W          = 21;
	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

	typedef struct packed {
		logic signed [ISUM_W-1:0] isum;
		logic [31:0]              a_f;
		logic [31:0]              b_f;
		logic                     last;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// Normalize and round sig * 2^e to float32, round to nearest even.
	function automatic logic [31:0] round_pack(input logic s, input logic [63:0] sig,
			input logic signed [12:0] e);
		logic [6:0]         lz;
		logic               found;
		logic [63:0]        norm;
		logic [63:0]        shv;
		logic signed [12:0] be;
		logic [12:0]        shamt;
		logic [23:0]        m;
		logic               g;
		logic               st;
		logic               lost;
		logic [24:0]        m25;
		logic [31:0]        r;
		lz = '0;
		found = 1'b0;
		for (int i = 63; i >= 0; i--) begin
			if (!found) begin
				if (sig[i]) found = 1'b1;
				else lz = lz + 7'd1;
			end
		end
		norm = sig << lz[5:0];
		be = e + 13'sd190 - $signed({6'd0, lz});
		if (be >= 13'sd1) begin
			m = norm[63:40];
			g = norm[39];
			st = |norm[38:0];
		end else begin
			shamt = 13'(13'sd1 - be);
			if (shamt >= 13'd64) begin
				shv = '0;
				lost = |norm;
			end else begin
				shv = norm >> shamt[5:0];
				lost = |(norm & ~({64{1'b1}} << shamt[5:0]));
			end
			m = shv[63:40];
			g = shv[39];
			st = (|shv[38:0]) | lost;
			be = 13'sd1;
		end
		m25 = {1'b0, m} + {24'd0, g & (st | m[0])};
		if (m25[24]) begin
			m = m25[24:1];
			be = be + 13'sd1;
		end else begin
			m = m25[23:0];
		end
		if (sig == '0) r = {s, 31'd0};
		else if (be >= 13'sd255) r = {s, 8'hFF, 23'd0};
		else r = {s, (m[23] ? be[7:0] : 8'h00), m[22:0]};
		return r;
	endfunction

	// Widen a binary16 pattern to binary32, exactly.
	function automatic logic [31:0] half_to_float(input logic [15:0] h);
		logic [4:0]  e5;
		logic [9:0]  m;
		logic [31:0] r;
		e5 = h[14:10];
		m = h[9:0];
		if (e5 == 5'd31) begin
			r = {h[15], 8'hFF, m, 13'd0} | ((m != 10'd0) ? 32'h0040_0000 : 32'd0);
		end else if (e5 == 5'd0 && m == 10'd0) begin
			r = {h[15], 31'd0};
		end else begin
			r = round_pack(h[15], {53'd0, (e5 != 5'd0), m},
				$signed({8'd0, ((e5 == 5'd0) ? 5'd1 : e5)}) - 13'sd25);
		end
		return r;
	endfunction

	// Convert the exact integer sum to float32.
	function automatic logic [31:0] int_to_float(input logic signed [ISUM_W-1:0] v);
		logic [ISUM_W-1:0] mag;
		mag = v[ISUM_W-1] ? ISUM_W'(-v) : ISUM_W'(v);
		return round_pack(v[ISUM_W-1], {{(64-ISUM_W){1'b0}}, mag}, 13'sd0);
	endfunction

	// Float32 multiply, round to nearest even.
	function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
		logic        s;
		logic [7:0]  eaf;
		logic [7:0]  ebf;
		logic        an, bn, ai, bi, az, bz;
		logic [47:0] p;
		logic [31:0] r;
		s = a[31] ^ b[31];
		an = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		bn = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		ai = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		bi = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		az = (a[30:0] == 31'd0);
		bz = (b[30:0] == 31'd0);
		eaf = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		ebf = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		p = {(a[30:23] != 8'd0), a[22:0]} * {(b[30:23] != 8'd0), b[22:0]};
		if (an || bn) r = CANON_NAN;
		else if (ai || bi) r = (az || bz) ? CANON_NAN : {s, 8'hFF, 23'd0};
		else if (az || bz) r = {s, 31'd0};
		else r = round_pack(s, {16'd0, p},
			$signed({5'd0, eaf}) + $signed({5'd0, ebf}) - 13'sd300);
		return r;
	endfunction

	// Float32 add, round to nearest even.
	function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
		logic        an, bn, ai, bi;
		logic [31:0] x;
		logic [31:0] y;
		logic [7:0]  exf;
		logic [7:0]  eyf;
		logic [7:0]  d;
		logic [49:0] big;
		logic [49:0] yfull;
		logic [49:0] y_al;
		logic [50:0] sum;
		logic        s;
		logic [31:0] r;
		an = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		bn = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		ai = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		bi = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		if (a[30:0] >= b[30:0]) begin
			x = a;
			y = b;
		end else begin
			x = b;
			y = a;
		end
		exf = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		eyf = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		d = exf - eyf;
		big = {(x[30:23] != 8'd0), x[22:0], 26'd0};
		yfull = {(y[30:23] != 8'd0), y[22:0], 26'd0};
		if (d >= 8'd50) begin
			y_al = {49'd0, |yfull};
		end else begin
			y_al = yfull >> d[5:0];
			y_al[0] = y_al[0] | (|(yfull & ~({50{1'b1}} << d[5:0])));
		end
		if (x[31] == y[31]) sum = {1'b0, big} + {1'b0, y_al};
		else sum = {1'b0, big} - {1'b0, y_al};
		s = (sum == '0) ? (a[31] & b[31]) : x[31];
		if (an || bn) r = CANON_NAN;
		else if (ai && bi && (a[31] != b[31])) r = CANON_NAN;
		else if (ai) r = a;
		else if (bi) r = b;
		else r = round_pack(s, {13'd0, sum}, $signed({5'd0, exf}) - 13'sd176);
		return r;
	endfunction

	// Signed dot product of eight packed byte pairs.
	function automatic logic signed [ISUM_W-1:0] dot8(input logic [63:0] a,
			input logic [63:0] b);
		logic signed [ISUM_W-1:0] acc;
		logic signed [15:0]       prod;
		acc = '0;
		for (int i = 0; i < BYTES_PER_WORD; i++) begin
			prod = $signed(a[8*i +: 8]) * $signed(b[8*i +: 8]);
			acc = acc + ISUM_W'(prod);
		end
		return acc;
	endfunction

endpackage

/* rtl/q8bd_front.sv */
// ---------------------------------------------------------------------------
// q8bd_front
// Accepts block pairs, widens scales, sums byte products one word a cycle.
// ---------------------------------------------------------------------------
module q8bd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             blk_valid,
	output logic             blk_stall,
	input  logic [63:0]      a_bytes_0,
	input  logic [63:0]      a_bytes_1,
	input  logic [63:0]      a_bytes_2,
	input  logic [63:0]      a_bytes_3,
	input  logic [63:0]      b_bytes_0,
	input  logic [63:0]      b_bytes_1,
	input  logic [63:0]      b_bytes_2,
	input  logic [63:0]      b_bytes_3,
	input  logic [15:0]      a_scale,
	input  logic [15:0]      b_scale,
	input  logic             last_block,
	input  q8bd_pkg::qstat_t qstat,
	output logic             push,
	output q8bd_pkg::entry_t push_entry
);
	import q8bd_pkg::*;

	logic [63:0]              a_sh_q [WORDS_PER_BLOCK];
	logic [63:0]              b_sh_q [WORDS_PER_BLOCK];
	logic [31:0]              af_q;
	logic [31:0]              bf_q;
	logic                     last_q;
	logic signed [ISUM_W-1:0] sum_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic                     take;

	assign blk_stall = busy_q;
	assign take = blk_valid && !busy_q;
	assign push = done_q && !qstat.full;
	assign push_entry = '{isum: sum_q, a_f: af_q, b_f: bf_q, last: last_q};

	// Control: take a beat, run the word loop, hand off to the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q && !done_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(WORDS_PER_BLOCK - 1)) done_q <= 1'b1;
		end else if (push) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end
	end

	// Payload: load words, advance the shift line, accumulate the sum.
	always_ff @(posedge clk) begin
		if (take) begin
			a_sh_q[0] <= a_bytes_0;
			a_sh_q[1] <= a_bytes_1;
			a_sh_q[2] <= a_bytes_2;
			a_sh_q[3] <= a_bytes_3;
			b_sh_q[0] <= b_bytes_0;
			b_sh_q[1] <= b_bytes_1;
			b_sh_q[2] <= b_bytes_2;
			b_sh_q[3] <= b_bytes_3;
			af_q <= half_to_float(a_scale);
			bf_q <= half_to_float(b_scale);
			last_q <= last_block;
			sum_q <= '0;
		end else if (busy_q && !done_q) begin
			sum_q <= sum_q + dot8(a_sh_q[0], b_sh_q[0]);
			for (int i = 0; i < WORDS_PER_BLOCK - 1; i++) begin
				a_sh_q[i] <= a_sh_q[i+1];
				b_sh_q[i] <= b_sh_q[i+1];
			end
		end
	end

endmodule

/* rtl/q8bd_queue.sv */
// ---------------------------------------------------------------------------
// q8bd_queue
// Two-entry queue between the front and the float back end.
// ---------------------------------------------------------------------------
module q8bd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  q8bd_pkg::entry_t push_entry,
	input  logic             pop,
	output q8bd_pkg::entry_t head,
	output q8bd_pkg::qstat_t qstat
);
	import q8bd_pkg::*;

	entry_t     slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] count_q;

	assign head = slot_q[rp_q];
	assign qstat = '{full: (count_q == 2'd2), empty: (count_q == 2'd0)};

	// Advance pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	// Write the pushed entry.
	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= push_entry;
	end

endmodule

/* rtl/q8bd_back.sv */
// ---------------------------------------------------------------------------
// q8bd_back
// Scales the integer sum, adds into the float32 accumulator, emits results.
// ---------------------------------------------------------------------------
module q8bd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  q8bd_pkg::entry_t head,
	input  q8bd_pkg::qstat_t qstat,
	output logic             pop,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [31:0]      dot_result
);
	`include "assert_macros.svh"
	import q8bd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_MUL2 = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]  st_q;
	logic [31:0] acc_q;
	entry_t      cur_q;
	logic [31:0] scale_q;
	logic [31:0] isf_q;
	logic [31:0] term_q;
	logic [31:0] res_q;
	logic        dot_valid_q;
	logic [31:0] dot_q;
	logic        slot_free;
	logic        emit;
	logic [31:0] sum;

	assign pop = (st_q == ST_IDLE) && !qstat.empty;
	assign slot_free = !dot_valid_q || !res_stall;
	assign emit = (st_q == ST_EMIT) && slot_free;
	assign sum = fadd(acc_q, term_q);
	assign res_valid = dot_valid_q;
	assign dot_result = dot_q;

	// Sequence one entry through the float steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			acc_q <= 32'd0;
			dot_valid_q <= 1'b0;
		end else begin
			// Load a new beat or hold the stalled one.
			dot_valid_q <= emit || (dot_valid_q && res_stall);
			case (st_q)
				ST_IDLE: begin
					if (pop) st_q <= ST_MUL1;
				end
				ST_MUL1: st_q <= ST_MUL2;
				ST_MUL2: st_q <= ST_ADD;
				ST_ADD: begin
					if (cur_q.last) begin
						st_q <= ST_EMIT;
					end else begin
						acc_q <= sum;
						st_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						acc_q <= 32'd0;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers for each step.
	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
		if (st_q == ST_MUL1) begin
			scale_q <= fmul(cur_q.a_f, cur_q.b_f);
			isf_q <= int_to_float(cur_q.isum);
		end
		if (st_q == ST_MUL2) term_q <= fmul(scale_q, isf_q);
		if (st_q == ST_ADD) res_q <= sum;
		if (st_q == ST_EMIT && slot_free) begin
			dot_q <= ((res_q[30:23] == 8'hFF) && (res_q[22:0] != 23'd0)) ? CANON_NAN
				: res_q;
		end
	end

	`ASSERT_NXT(a_mul_order, st_q == ST_MUL1, st_q == ST_MUL2)
	`ASSERT_IMP(a_emit_last, st_q == ST_EMIT, cur_q.last)
	`ASSERT_IMP(a_valid_src, $rose(dot_valid_q), $past(st_q == ST_EMIT))
	`ASSERT_IMP(a_pop_idle, pop, !qstat.empty && st_q == ST_IDLE)

endmodule

/* rtl/q8_block_dot_accumulate.sv */
// ---------------------------------------------------------------------------
// q8_block_dot_accumulate
// Q8_0-style block dot product with a float32 accumulator.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (blk_valid / blk_stall) takes one beat per block pair:
//   32 signed bytes and a half scale per side, plus last_block.
//   Output channel (res_valid / res_stall) gives one float32 beat per dot
//   product, on the block pair marked last.
//   The front takes a beat, then sums one 8-byte word per cycle, four words
//   in all, and pushes into a two-entry queue before it takes the next beat.
//   The back steps each entry through pop, scale multiply, sum multiply
//   and accumulate add; a last entry adds an emit step to load the output.
//   Reset clears the accumulator to +0, empties the queue, drops res_valid.
//   While res_stall is high the result holds; once the back waits to emit,
//   the queue fills and the front, unable to push, keeps blk_stall high.
// ---------------------------------------------------------------------------
module q8_block_dot_accumulate (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        blk_valid,
	output logic        blk_stall,
	input  logic [63:0] a_bytes_0,
	input  logic [63:0] a_bytes_1,
	input  logic [63:0] a_bytes_2,
	input  logic [63:0] a_bytes_3,
	input  logic [63:0] b_bytes_0,
	input  logic [63:0] b_bytes_1,
	input  logic [63:0] b_bytes_2,
	input  logic [63:0] b_bytes_3,
	input  logic [15:0] a_scale,
	input  logic [15:0] b_scale,
	input  logic        last_block,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [31:0] dot_result
);
	import q8bd_pkg::*;

	entry_t push_entry;
	entry_t head;
	qstat_t qstat;
	logic   push;
	logic   pop;

	q8bd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.blk_valid  (blk_valid),
		.blk_stall  (blk_stall),
		.a_bytes_0  (a_bytes_0),
		.a_bytes_1  (a_bytes_1),
		.a_bytes_2  (a_bytes_2),
		.a_bytes_3  (a_bytes_3),
		.b_bytes_0  (b_bytes_0),
		.b_bytes_1  (b_bytes_1),
		.b_bytes_2  (b_bytes_2),
		.b_bytes_3  (b_bytes_3),
		.a_scale    (a_scale),
		.b_scale    (b_scale),
		.last_block (last_block),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	q8bd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	q8bd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.qstat      (qstat),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.dot_result (dot_result)
	);

endmodule
